@@ src/stpg_pkg.sv @@
// shared types, constants and table function of the sine tone generator
package stpg_pkg;

    localparam int unsigned MAX_CHANNELS = 8;
    localparam int unsigned CH_W         = 3;
    localparam int unsigned MAG_W        = 18;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned ADDR_W       = 5;

    localparam logic [MAG_W-1:0] ONE_Q17 = 18'd131072;

    localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] REG_SAMPLE_BITS  = 3'd1;
    localparam logic [2:0] REG_PHYS_BYTES   = 3'd2;
    localparam logic [2:0] REG_MSB_FIRST    = 3'd3;
    localparam logic [2:0] REG_UNSIGNED_OUT = 3'd4;
    localparam logic [2:0] REG_CHANNEL_CNT  = 3'd5;

    localparam logic [31:0] RST_PHASE_STEP  = 32'd39370534;
    localparam logic [5:0]  RST_SAMPLE_BITS = 6'd16;
    localparam logic [2:0]  RST_PHYS_BYTES  = 3'd2;
    localparam logic [3:0]  RST_CHANNEL_CNT = 4'd2;

    typedef struct packed {
        logic [31:0] phase_step;
        logic [5:0]  sample_bits;
        logic [2:0]  phys_bytes;
        logic        msb_first;
        logic        unsigned_out;
        logic [3:0]  channel_count;
    } t_cfg;

    // two multiplications by theta in Q30
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] th);
        logic [63:0] t1;
        t1 = (term * th) >> 30;
        return (t1 * th) >> 30;
    endfunction

    function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : 64'd0;
    endfunction

    // quarter-wave entry k of a table with 2^t steps, Q1.17
    function automatic logic [MAG_W-1:0] sine_q17(input int unsigned k, input int unsigned t);
        logic [63:0] th;
        logic [63:0] term;
        logic [63:0] sum;
        th   = (64'd1686629713 * 64'(k)) >> t;
        term = th;
        sum  = th;
        term = sq_step(term, th) / 64'd6;
        sum  = sub_sat(sum, term);
        term = sq_step(term, th) / 64'd20;
        sum  = sum + term;
        term = sq_step(term, th) / 64'd42;
        sum  = sub_sat(sum, term);
        term = sq_step(term, th) / 64'd72;
        sum  = sum + term;
        term = sq_step(term, th) / 64'd110;
        sum  = sub_sat(sum, term);
        term = sq_step(term, th) / 64'd156;
        sum  = sum + term;
        term = sq_step(term, th) / 64'd210;
        sum  = sub_sat(sum, term);
        term = sq_step(term, th) / 64'd272;
        sum  = sum + term;
        sum  = (sum + 64'd4096) >> 13;
        return (sum > 64'(ONE_Q17)) ? ONE_Q17 : sum[MAG_W-1:0];
    endfunction

endpackage

@@ src/stpg_stream_if.sv @@
// frame request and sample item channel interfaces
interface stpg_in_if;
    logic valid;
    logic ready;
    logic last_frame;

    modport source (output valid, output last_frame, input ready);
    modport sink (input valid, input last_frame, output ready);
endinterface

interface stpg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_word;
    logic [2:0]  channel_index;
    logic        end_of_frame;
    logic        end_of_block;

    modport source (
        output valid, output sample_word, output channel_index,
        output end_of_frame, output end_of_block, input ready
    );
    modport sink (
        input valid, input sample_word, input channel_index,
        input end_of_frame, input end_of_block, output ready
    );
endinterface

@@ src/stpg_cfg_regs.sv @@
// apb configuration registers
module stpg_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [stpg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output stpg_pkg::t_cfg            o_cfg
);

    stpg_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[stpg_pkg::ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step    <= stpg_pkg::RST_PHASE_STEP;
            r_cfg.sample_bits   <= stpg_pkg::RST_SAMPLE_BITS;
            r_cfg.phys_bytes    <= stpg_pkg::RST_PHYS_BYTES;
            r_cfg.msb_first     <= 1'b0;
            r_cfg.unsigned_out  <= 1'b0;
            r_cfg.channel_count <= stpg_pkg::RST_CHANNEL_CNT;
        end else if (wr_en) begin
            unique case (reg_idx)
                stpg_pkg::REG_PHASE_STEP:   r_cfg.phase_step    <= pwdata;
                stpg_pkg::REG_SAMPLE_BITS:  r_cfg.sample_bits   <= pwdata[5:0];
                stpg_pkg::REG_PHYS_BYTES:   r_cfg.phys_bytes    <= pwdata[2:0];
                stpg_pkg::REG_MSB_FIRST:    r_cfg.msb_first     <= pwdata[0];
                stpg_pkg::REG_UNSIGNED_OUT: r_cfg.unsigned_out  <= pwdata[0];
                stpg_pkg::REG_CHANNEL_CNT:  r_cfg.channel_count <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            stpg_pkg::REG_PHASE_STEP:   prdata = r_cfg.phase_step;
            stpg_pkg::REG_SAMPLE_BITS:  prdata = {26'd0, r_cfg.sample_bits};
            stpg_pkg::REG_PHYS_BYTES:   prdata = {29'd0, r_cfg.phys_bytes};
            stpg_pkg::REG_MSB_FIRST:    prdata = {31'd0, r_cfg.msb_first};
            stpg_pkg::REG_UNSIGNED_OUT: prdata = {31'd0, r_cfg.unsigned_out};
            stpg_pkg::REG_CHANNEL_CNT:  prdata = {28'd0, r_cfg.channel_count};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

@@ src/stpg_sine_rom.sv @@
// quarter-wave sine rom with registered read
module stpg_sine_rom #(
    parameter int unsigned TABLE_ADDR_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [TABLE_ADDR_BITS:0]   i_idx,
    output logic [stpg_pkg::MAG_W-1:0] o_mag
);

    localparam int unsigned Span = 1 << TABLE_ADDR_BITS;

    typedef logic [stpg_pkg::MAG_W-1:0] t_tab [Span+1];

    function automatic t_tab build_tab();
        t_tab tab;
        for (int unsigned k = 0; k <= Span; k++) begin
            tab[k] = stpg_pkg::sine_q17(k, TABLE_ADDR_BITS);
        end
        return tab;
    endfunction

    localparam t_tab SineTab = build_tab();

    logic [stpg_pkg::MAG_W-1:0] r_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= SineTab[i_idx];
        end
    end

    assign o_mag = r_mag;

endmodule

@@ src/stpg_sample_fmt.sv @@
// scaling, sign handling and byte packing of one sample
module stpg_sample_fmt (
    input  stpg_pkg::t_cfg              i_cfg,
    input  logic [stpg_pkg::MAG_W-1:0]  i_mag,
    input  logic                        i_neg,
    output logic [stpg_pkg::WORD_W-1:0] o_word
);

    logic [5:0]  bits;
    logic [2:0]  phys;
    logic [2:0]  nbytes;
    logic [31:0] full;
    logic [48:0] prod;
    logic [31:0] q;
    logic [31:0] r;
    logic [2:0]  pos;
    logic [31:0] word;

    always_comb begin
        if (i_cfg.sample_bits < 6'd8) begin
            bits = 6'd8;
        end else if (i_cfg.sample_bits > 6'd32) begin
            bits = 6'd32;
        end else begin
            bits = i_cfg.sample_bits;
        end

        if (i_cfg.phys_bytes == 3'd0) begin
            phys = 3'd1;
        end else if (i_cfg.phys_bytes > 3'd4) begin
            phys = 3'd4;
        end else begin
            phys = i_cfg.phys_bytes;
        end

        nbytes = (bits[5:3] > phys) ? phys : bits[5:3];

        full = (32'd1 << (bits - 6'd1)) - 32'd1;
        prod = {31'd0, i_mag} * {18'd0, full[30:0]};
        q    = prod[48:17];
        r    = i_neg ? (32'd0 - q) : q;
        if (i_cfg.unsigned_out) begin
            r = r ^ (32'd1 << (bits - 6'd1));
        end

        word = '0;
        pos  = '0;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < nbytes) begin
                pos = i_cfg.msb_first ? (phys - 3'd1 - 3'(i)) : 3'(i);
                word[8*pos[1:0] +: 8] = r[8*i +: 8];
            end
        end
    end

    assign o_word = word;

endmodule

@@ src/sine_tone_pcm_generator_unit.sv @@
// sine tone pcm generator top level
// usage:
//   each item on i_frame requests one audio frame; last_frame marks the final
//   frame of a block. for every frame the block sends channel_count items on
//   o_sample (one if it is 0, at most eight), channel 0 first, all carrying
//   the same packed sample word, with end_of_frame on the last channel and
//   end_of_block on it for the last frame. the user writes registers over
//   the apb port only while the block is idle; the block does not enforce it.
// timing:
//   the first item of a frame is presented after the frame passes the rom
//   stage (rom read on the accepting edge, then scale and pack into the output
//   register). the output register sends one item per cycle while
//   o_sample.ready is high, holding each frame until all of its channels are
//   sent. a frame waits in the rom stage while the previous one drains.
// reset and stall:
//   reset clears the phase accumulator, the stage valid bits and loads the
//   register defaults. when o_sample.ready is low the current item holds and
//   i_frame.ready drops once the rom stage is full.
module sine_tone_pcm_generator_unit #(
    parameter int unsigned PHASE_BITS      = 32,
    parameter int unsigned TABLE_ADDR_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [stpg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    stpg_in_if.sink                     i_frame,
    stpg_out_if.source                  o_sample
);

    localparam logic [TABLE_ADDR_BITS:0] Span = (TABLE_ADDR_BITS+1)'(1) << TABLE_ADDR_BITS;

    stpg_pkg::t_cfg cfg;

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      step;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS:0]   addr;
    logic [TABLE_ADDR_BITS:0]   rom_idx;
    logic [stpg_pkg::MAG_W-1:0] mag;
    logic [stpg_pkg::WORD_W-1:0] fmt_word;

    logic r_s1_vld;
    logic r_s1_neg;
    logic r_s1_last;

    logic                        r_em_vld;
    logic [stpg_pkg::WORD_W-1:0] r_em_word;
    logic [stpg_pkg::CH_W-1:0]   r_em_cnt;
    logic                        r_em_last;

    logic [stpg_pkg::CH_W-1:0] last_ch;
    logic in_acc;
    logic out_acc;
    logic em_done;
    logic em_free;
    logic s1_move;
    logic s1_free;

    stpg_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        if (cfg.channel_count == 4'd0) begin
            last_ch = '0;
        end else if (cfg.channel_count > 4'(stpg_pkg::MAX_CHANNELS)) begin
            last_ch = stpg_pkg::CH_W'(stpg_pkg::MAX_CHANNELS - 1);
        end else begin
            last_ch = stpg_pkg::CH_W'(cfg.channel_count - 4'd1);
        end
    end

    // phase to rom index, mirrored in odd quadrants
    assign quad    = r_phase[PHASE_BITS-1 -: 2];
    assign addr    = {1'b0, r_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
    assign rom_idx = quad[0] ? (Span - addr) : addr;

    generate
        if (PHASE_BITS > 32) begin : g_step_wide
            assign step = {{(PHASE_BITS-32){1'b0}}, cfg.phase_step};
        end else begin : g_step_narrow
            assign step = cfg.phase_step[PHASE_BITS-1:0];
        end
    endgenerate

    assign in_acc  = i_frame.valid & i_frame.ready;
    assign out_acc = o_sample.valid & o_sample.ready;
    assign em_done = out_acc & (r_em_cnt == last_ch);
    assign em_free = ~r_em_vld | em_done;
    assign s1_move = r_s1_vld & em_free;
    assign s1_free = ~r_s1_vld | em_free;

    assign i_frame.ready = s1_free;

    stpg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (in_acc),
        .i_idx (rom_idx),
        .o_mag (mag)
    );

    stpg_sample_fmt u_fmt (
        .i_cfg  (cfg),
        .i_mag  (mag),
        .i_neg  (r_s1_neg),
        .o_word (fmt_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase  <= r_phase + step;
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_neg  <= quad[1];
            r_s1_last <= i_frame.last_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
            r_em_cnt <= '0;
        end else begin
            if (s1_move) begin
                r_em_vld <= 1'b1;
                r_em_cnt <= '0;
            end else if (em_done) begin
                r_em_vld <= 1'b0;
                r_em_cnt <= '0;
            end else if (out_acc) begin
                r_em_cnt <= r_em_cnt + stpg_pkg::CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_em_word <= fmt_word;
            r_em_last <= r_s1_last;
        end
    end

    assign o_sample.valid         = r_em_vld;
    assign o_sample.sample_word   = r_em_word;
    assign o_sample.channel_index = r_em_cnt;
    assign o_sample.end_of_frame  = (r_em_cnt == last_ch);
    assign o_sample.end_of_block  = (r_em_cnt == last_ch) & r_em_last;

    a_phase_only_on_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_phase)
    ) else $error("phase moved without a frame item");

    a_rom_stage_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !em_free |=> r_s1_vld && $stable(r_s1_neg) && $stable(r_s1_last)
    ) else $error("rom stage changed while blocked");

    a_frame_restarts_at_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_sample.end_of_frame |=> !o_sample.valid || o_sample.channel_index == '0
    ) else $error("new frame did not start at channel zero");

    a_count_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_em_vld |-> r_em_cnt <= last_ch
    ) else $error("channel count beyond last channel");

endmodule
